>>> src/dasc_pkg.sv
// dasc_pkg: shared widths, codes, types and helpers for the actuator sync controller
// depends on nothing; imported by every module of the block
package dasc_pkg;

    localparam int POS_W      = 32;
    localparam int DUTY_FRAC  = 14;
    localparam int CORR_FRAC  = 24;
    localparam int GAIN_W     = 16;
    localparam int BAND_W     = 31;
    localparam int DUTY_W     = 16;
    localparam int MODE_W     = 2;
    localparam int DIR_W      = 2;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 4;
    localparam int REG_IDX_W  = 2;

    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 40;

    localparam int PROD_W     = GAIN_W + POS_W;
    localparam int CORR_SHIFT = CORR_FRAC - DUTY_FRAC;
    localparam int F24_W      = CORR_FRAC + 1;
    localparam int F_W        = F24_W - CORR_SHIFT;
    localparam int CAP_W      = CORR_FRAC + 2;
    localparam int TT_W       = 15;
    localparam int CM_PROD_W  = CAP_W + TT_W;
    localparam int CM_SHIFT   = CORR_FRAC + 16 - DUTY_FRAC;
    localparam int CM_W       = CM_PROD_W - CM_SHIFT;

    localparam logic [TT_W-1:0]   THREE_TENTHS = TT_W'(19661);
    localparam logic [PROD_W-1:0] CORR_UNIT    = PROD_W'(1) << CORR_FRAC;
    localparam logic [PROD_W-1:0] CORR_CAP     = PROD_W'(2) << CORR_FRAC;
    localparam logic [CM_W-1:0]   CM_HALF      = CM_W'(1) << (DUTY_FRAC - 1);

    localparam logic [GAIN_W-1:0] PROP_GAIN_RST  = GAIN_W'(384);
    localparam logic [GAIN_W-1:0] DERIV_GAIN_RST = GAIN_W'(102);
    localparam logic [BAND_W-1:0] DEAD_BAND_RST  = BAND_W'(3277);

    localparam logic [REG_IDX_W-1:0] REG_PROP_GAIN  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_DERIV_GAIN = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_DEAD_BAND  = 2'd2;

    localparam logic [MODE_W-1:0] MODE_PLAIN = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SLOW  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_IDLE  = 2'd2;

    localparam logic CMD_SAMPLE  = 1'b0;
    localparam logic CMD_CONTROL = 1'b1;

    typedef logic signed [POS_W-1:0]  pos_t;
    typedef logic signed [DUTY_W-1:0] duty_t;

    typedef struct packed {
        logic [GAIN_W-1:0] prop_gain;
        logic [GAIN_W-1:0] deriv_gain;
        logic [BAND_W-1:0] dead_band;
    } cfg_t;

    typedef struct packed {
        logic sample_load;
        logic ctrl_load;
        logic err_en;
        logic rate_en;
        logic mul_en;
        logic mul2_en;
        logic out_load;
    } ctl_t;

    function automatic pos_t sat_pos(input logic signed [POS_W:0] x);
        pos_t r;
        if (x[POS_W] != x[POS_W-1])
            r = x[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
        else
            r = x[POS_W-1:0];
        return r;
    endfunction

    function automatic logic [POS_W-1:0] abs_pos(input pos_t x);
        logic [POS_W:0] ext;
        logic [POS_W:0] neg;
        ext = {x[POS_W-1], x};
        neg = -ext;
        return x[POS_W-1] ? neg[POS_W-1:0] : x;
    endfunction

endpackage

>>> src/dasc_regs.sv
// dasc_regs: apb configuration registers (gains and deadband)
// depends on dasc_pkg
module dasc_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [dasc_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [dasc_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [dasc_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready,
    output dasc_pkg::cfg_t                 cfg
);
    import dasc_pkg::*;

    logic [GAIN_W-1:0]    prop_gain_reg;
    logic [GAIN_W-1:0]    deriv_gain_reg;
    logic [BAND_W-1:0]    dead_band_reg;
    logic [REG_IDX_W-1:0] idx;
    logic                 wr;

    assign idx    = paddr[CFG_ADDR_W-1:2];
    assign wr     = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prop_gain_reg  <= PROP_GAIN_RST;
            deriv_gain_reg <= DERIV_GAIN_RST;
            dead_band_reg  <= DEAD_BAND_RST;
        end
        else if (wr)
        begin
            case (idx)
                REG_PROP_GAIN:  prop_gain_reg  <= pwdata[GAIN_W-1:0];
                REG_DERIV_GAIN: deriv_gain_reg <= pwdata[GAIN_W-1:0];
                REG_DEAD_BAND:  dead_band_reg  <= pwdata[BAND_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_PROP_GAIN:  prdata = CFG_DATA_W'(prop_gain_reg);
            REG_DERIV_GAIN: prdata = CFG_DATA_W'(deriv_gain_reg);
            REG_DEAD_BAND:  prdata = CFG_DATA_W'(dead_band_reg);
            default:        prdata = '0;
        endcase
    end

    assign cfg.prop_gain  = prop_gain_reg;
    assign cfg.deriv_gain = deriv_gain_reg;
    assign cfg.dead_band  = dead_band_reg;

endmodule

>>> src/dasc_ctrl.sv
// dasc_ctrl: sequencer for the sync datapath and output word handshake
// depends on dasc_pkg
module dasc_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_tvalid,
    input  logic           s_cmd,
    input  logic           m_tready,
    output logic           s_tready,
    output logic           m_tvalid,
    output dasc_pkg::ctl_t ctl
);
    import dasc_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ERR,
        ST_RATE,
        ST_MUL,
        ST_MUL2,
        ST_FIN
    } state_t;

    state_t state_reg;
    logic   m_tvalid_reg;
    logic   accept;
    logic   load_out;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign load_out = (state_reg == ST_FIN) && (!m_tvalid_reg || m_tready);
    assign m_tvalid = m_tvalid_reg;

    always_comb
    begin
        ctl             = '0;
        ctl.sample_load = accept && (s_cmd == CMD_SAMPLE);
        ctl.ctrl_load   = accept && (s_cmd == CMD_CONTROL);
        ctl.err_en      = (state_reg == ST_ERR);
        ctl.rate_en     = (state_reg == ST_RATE);
        ctl.mul_en      = (state_reg == ST_MUL);
        ctl.mul2_en     = (state_reg == ST_MUL2);
        ctl.out_load    = load_out;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (load_out)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE:
                begin
                    if (accept && (s_cmd == CMD_CONTROL))
                        state_reg <= ST_ERR;
                end
                ST_ERR:  state_reg <= ST_RATE;
                ST_RATE: state_reg <= ST_MUL;
                ST_MUL:  state_reg <= ST_MUL2;
                ST_MUL2: state_reg <= ST_FIN;
                ST_FIN:
                begin
                    if (load_out)
                        state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

>>> src/dasc_datapath.sv
// dasc_datapath: offset, error, rate, gain products and duty shaping
// depends on dasc_pkg; sequenced by dasc_ctrl
module dasc_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  dasc_pkg::ctl_t                ctl,
    input  dasc_pkg::cfg_t                cfg,
    input  dasc_pkg::pos_t                left_pos,
    input  dasc_pkg::pos_t                right_pos,
    input  logic signed [dasc_pkg::DIR_W-1:0] direction,
    output dasc_pkg::duty_t               left_drive,
    output dasc_pkg::duty_t               right_drive,
    output logic [dasc_pkg::MODE_W-1:0]   sync_mode
);
    import dasc_pkg::*;

    pos_t                   diff_reg;
    pos_t                   offset_reg;
    logic                   latched_reg;
    pos_t                   last_err_reg;
    logic signed [DIR_W-1:0] dir_reg;
    pos_t                   err_reg;
    pos_t                   rate_reg;
    logic [POS_W-1:0]       emag_reg;
    logic [PROD_W-1:0]      p_reg;
    logic [PROD_W-1:0]      q_reg;
    logic                   band_reg;
    logic [F_W-1:0]         f_reg;
    logic [CM_PROD_W-1:0]   cm_prod_reg;
    duty_t                  left_drive_reg;
    duty_t                  right_drive_reg;
    logic [MODE_W-1:0]      mode_reg;

    pos_t                   sample_diff;
    logic [PROD_W-1:0]      corr;
    logic [F24_W-1:0]       f24;
    logic [CAP_W-1:0]       pm;
    logic [CM_W-1:0]        cm;
    logic [CM_W-1:0]        cm_cap;
    duty_t                  half_mag;
    duty_t                  unit_duty;
    duty_t                  slowed;
    duty_t                  left_next;
    duty_t                  right_next;
    logic [MODE_W-1:0]      mode_next;
    logic                   err_pos;
    logic                   right_slow;

    assign sample_diff = sat_pos({right_pos[POS_W-1], right_pos} - {left_pos[POS_W-1], left_pos});

    // state that persists across items
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            diff_reg     <= '0;
            offset_reg   <= '0;
            latched_reg  <= 1'b0;
            last_err_reg <= '0;
        end
        else
        begin
            if (ctl.sample_load)
            begin
                diff_reg <= sample_diff;
                if (!latched_reg)
                begin
                    offset_reg  <= sample_diff;
                    latched_reg <= 1'b1;
                end
            end
            if (ctl.rate_en)
                last_err_reg <= err_reg;
        end
    end

    // corrected gain term and idle correction product
    always_comb
    begin
        corr = (p_reg > q_reg) ? (p_reg - q_reg) : '0;
        f24  = (corr >= CORR_UNIT) ? '0 : F24_W'(CORR_UNIT - corr);
        pm   = (p_reg > CORR_CAP) ? CORR_CAP[CAP_W-1:0] : p_reg[CAP_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.ctrl_load)
            dir_reg <= (direction == -2'sd2) ? -2'sd1 : direction;
        if (ctl.err_en)
            err_reg <= sat_pos({diff_reg[POS_W-1], diff_reg} - {offset_reg[POS_W-1], offset_reg});
        if (ctl.rate_en)
        begin
            rate_reg <= sat_pos({err_reg[POS_W-1], err_reg}
                                - {last_err_reg[POS_W-1], last_err_reg});
            emag_reg <= abs_pos(err_reg);
        end
        if (ctl.mul_en)
        begin
            p_reg    <= PROD_W'(cfg.prop_gain) * PROD_W'(emag_reg);
            q_reg    <= PROD_W'(cfg.deriv_gain) * PROD_W'(abs_pos(rate_reg));
            band_reg <= emag_reg > POS_W'(cfg.dead_band);
        end
        if (ctl.mul2_en)
        begin
            f_reg       <= f24[F24_W-1:CORR_SHIFT];
            cm_prod_reg <= CM_PROD_W'(pm) * CM_PROD_W'(THREE_TENTHS);
        end
        if (ctl.out_load)
        begin
            left_drive_reg  <= left_next;
            right_drive_reg <= right_next;
            mode_reg        <= mode_next;
        end
    end

    // duty shaping
    always_comb
    begin
        unit_duty  = duty_t'(1) <<< DUTY_FRAC;
        cm         = cm_prod_reg[CM_PROD_W-1:CM_SHIFT];
        cm_cap     = (cm > CM_HALF) ? CM_HALF : cm;
        half_mag   = DUTY_W'(cm_cap >> 1);
        slowed     = (dir_reg > 0) ? DUTY_W'(f_reg) : -DUTY_W'(f_reg);
        err_pos    = !err_reg[POS_W-1] && (err_reg != '0);
        right_slow = err_pos ? (dir_reg > 0) : (dir_reg < 0);
        case (dir_reg)
            2'sd1:   left_next = unit_duty;
            -2'sd1:  left_next = -unit_duty;
            default: left_next = '0;
        endcase
        right_next = left_next;
        mode_next  = MODE_PLAIN;
        if (band_reg)
        begin
            if (dir_reg != '0)
            begin
                if (right_slow)
                    right_next = slowed;
                else
                    left_next = slowed;
                mode_next = MODE_SLOW;
            end
            else
            begin
                left_next  = err_reg[POS_W-1] ? -half_mag : half_mag;
                right_next = -left_next;
                mode_next  = MODE_IDLE;
            end
        end
    end

    assign left_drive  = left_drive_reg;
    assign right_drive = right_drive_reg;
    assign sync_mode   = mode_reg;

endmodule

>>> src/dual_actuator_sync_controller.sv
// dual_actuator_sync_controller: top level of the paired actuator sync block
// depends on dasc_pkg, dasc_regs, dasc_ctrl, dasc_datapath
//
//  channel  | direction | word / fields (low bit up)
//  ---------+-----------+------------------------------------------------------
//  s_*      | in        | tuser: cmd; tdata: left_pos, right_pos, direction
//  m_*      | out       | tdata: left_drive, right_drive, sync_mode
//  apb      | in/out    | prop_gain @0x0, deriv_gain @0x4, dead_band @0x8
//
//  a position sample is latched when accepted and gives no output word
//  a control step runs through accept, error, rate, gain multiply,
//  correction multiply and output load, in that order
//  the output register holds a finished word while the next item is accepted;
//  a stalled output holds the next control step in its last stage
//  reset restores the register defaults and clears offset, readings and last error
module dual_actuator_sync_controller (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [dasc_pkg::IN_DATA_W-1:0]   s_tdata,  // left_pos, right_pos, direction
    input  logic                             s_tuser,  // cmd
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [dasc_pkg::OUT_DATA_W-1:0]  m_tdata,  // left_drive, right_drive, sync_mode
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [dasc_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [dasc_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [dasc_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                             pready
);
    import dasc_pkg::*;

    cfg_t              cfg;
    ctl_t              ctl;
    duty_t             left_drive;
    duty_t             right_drive;
    logic [MODE_W-1:0] sync_mode;

    dasc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    dasc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_cmd    (s_tuser),
        .m_tready (m_tready),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .ctl      (ctl)
    );

    dasc_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .cfg         (cfg),
        .left_pos    (s_tdata[POS_W-1:0]),
        .right_pos   (s_tdata[2*POS_W-1:POS_W]),
        .direction   (s_tdata[2*POS_W+DIR_W-1:2*POS_W]),
        .left_drive  (left_drive),
        .right_drive (right_drive),
        .sync_mode   (sync_mode)
    );

    assign m_tdata = {(OUT_DATA_W-2*DUTY_W-MODE_W)'(0), sync_mode, right_drive, left_drive};

endmodule

>>> src/dasc_checker.sv
// dasc_checker: port-level checks on the sync controller, bound to the top level
// depends on dasc_pkg and dual_actuator_sync_controller
module dasc_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            s_tuser,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [dasc_pkg::OUT_DATA_W-1:0] m_tdata
);
    import dasc_pkg::*;

    logic signed [DUTY_W-1:0] left_d;
    logic signed [DUTY_W-1:0] right_d;
    logic [MODE_W-1:0]        mode;

    assign left_d  = m_tdata[DUTY_W-1:0];
    assign right_d = m_tdata[2*DUTY_W-1:DUTY_W];
    assign mode    = m_tdata[2*DUTY_W+MODE_W-1:2*DUTY_W];

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output word dropped while stalled");

    a_busy_after_ctrl: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser |=> !s_tready)
        else $error("input taken during control step");

    a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (left_d <= 16'sd16384) && (left_d >= -16'sd16384)
                  && (right_d <= 16'sd16384) && (right_d >= -16'sd16384))
        else $error("duty out of range");

    a_plain_equal: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (mode == MODE_PLAIN) |-> left_d == right_d)
        else $error("plain mode with unequal duties");

    a_idle_mirror: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (mode == MODE_IDLE) |-> left_d == -right_d)
        else $error("idle correction not mirrored");

endmodule

bind dual_actuator_sync_controller dasc_checker u_dasc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
